>>> src/nscc_pkg.sv
// Package for the NMEA sentence checksum checker.
// Holds the beat payload types, verdict codes and character constants.
// No dependencies; every other file in src imports it.
package nscc_pkg;

    localparam int unsigned MAX_FIELDS = 20;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [8:0] HEX_ALPHA_OFS = 9'd55;   // 'A' - 10
    localparam logic [8:0] HEX_DIGIT_OFS = 9'd48;   // '0'

    typedef enum logic [1:0] {
        POLICY_STRICT     = 2'd0,
        POLICY_BAD_ONLY   = 2'd1,
        POLICY_ACCEPT_ALL = 2'd2,
        POLICY_ACCEPT_ALT = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        VERDICT_GOOD      = 3'd0,
        VERDICT_NOSUM_OK  = 3'd1,
        VERDICT_BAD_OK    = 3'd2,
        VERDICT_BAD_REJ   = 3'd3,
        VERDICT_MISS_REJ  = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_last;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [7:0] computed_sum;
        logic [4:0] field_count;
    } out_beat_t;

    // Hex digit decode without validation: above '9' minus 55, else minus 48.
    function automatic logic signed [8:0] hex_value(input logic [7:0] b);
        logic [8:0] ext;
        begin
            ext = {1'b0, b};
            if (b > CH_NINE)
            begin
                hex_value = $signed(ext - HEX_ALPHA_OFS);
            end
            else
            begin
                hex_value = $signed(ext - HEX_DIGIT_OFS);
            end
        end
    endfunction

endpackage

>>> src/nscc_parser.sv
// Sentence parser: phase tracking, running XOR, comma count, digit decode.
// Emits the verdict for the line on its last byte. Depends on nscc_pkg.
module nscc_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  nscc_pkg::in_beat_t  beat,
    input  logic [1:0]          policy,
    output logic                res_valid,
    output nscc_pkg::out_beat_t res
);
    import nscc_pkg::*;

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_BODY   = 3'd1,
        PH_DIG1   = 3'd2,
        PH_DIG2   = 3'd3,
        PH_HAVE   = 3'd4,
        PH_NOSUM  = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         xor_reg, xor_next;
    logic signed [8:0]  first_digit_reg, first_digit_next;
    logic signed [12:0] received_reg, received_next;
    logic [4:0]         comma_reg, comma_next;
    logic signed [8:0]  digit;
    logic [2:0]         bad_code;
    logic [2:0]         miss_code;
    logic [2:0]         verdict;

    assign digit = hex_value(beat.line_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        xor_next         = xor_reg;
        first_digit_next = first_digit_reg;
        received_next    = received_reg;
        comma_next       = comma_reg;
        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (beat.line_byte == CH_DOLLAR)
                begin
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (beat.line_byte < CH_SPACE)
                begin
                    phase_next = PH_NOSUM;
                end
                else if (beat.line_byte == CH_STAR)
                begin
                    phase_next = PH_DIG1;
                end
                else
                begin
                    xor_next = xor_reg ^ beat.line_byte;
                    if (beat.line_byte == CH_COMMA && comma_reg < 5'(MAX_FIELDS))
                    begin
                        comma_next = comma_reg + 5'd1;
                    end
                end
            end
            PH_DIG1:
            begin
                first_digit_next = digit;
                phase_next       = PH_DIG2;
            end
            PH_DIG2:
            begin
                received_next = {first_digit_reg, 4'b0000} + 13'(digit);
                phase_next    = PH_HAVE;
            end
            default:
            begin
            end
        endcase
    end

    assign bad_code  = (policy <= POLICY_BAD_ONLY) ? VERDICT_BAD_REJ : VERDICT_BAD_OK;
    assign miss_code = (policy == POLICY_STRICT) ? VERDICT_MISS_REJ : VERDICT_NOSUM_OK;

    always_comb
    begin
        unique case (phase_next)
            PH_BODY, PH_NOSUM:
            begin
                verdict = miss_code;
            end
            PH_HAVE:
            begin
                verdict = (received_next == $signed({5'b00000, xor_next})) ? VERDICT_GOOD
                                                                            : bad_code;
            end
            default:
            begin
                verdict = bad_code;
            end
        endcase
    end

    assign res_valid        = beat.line_last && (phase_next != PH_SEARCH);
    assign res.verdict      = verdict;
    assign res.computed_sum = xor_next;
    assign res.field_count  = comma_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SEARCH;
            xor_reg         <= '0;
            first_digit_reg <= '0;
            received_reg    <= '0;
            comma_reg       <= '0;
        end
        else if (step)
        begin
            if (beat.line_last)
            begin
                phase_reg       <= PH_SEARCH;
                xor_reg         <= '0;
                first_digit_reg <= '0;
                received_reg    <= '0;
                comma_reg       <= '0;
            end
            else
            begin
                phase_reg       <= phase_next;
                xor_reg         <= xor_next;
                first_digit_reg <= first_digit_next;
                received_reg    <= received_next;
                comma_reg       <= comma_next;
            end
        end
    end

endmodule

>>> src/nscc_out_reg.sv
// Result register for the checker's output channel.
// Holds one verdict beat until the consumer takes it. Depends on nscc_pkg.
module nscc_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  nscc_pkg::out_beat_t load_data,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output nscc_pkg::out_beat_t out_data
);
    import nscc_pkg::*;

    logic      valid_reg;
    out_beat_t data_reg;

    // Room next edge when empty or when the held beat leaves now.
    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

>>> src/nmea_sentence_checksum_checker.sv
// Top level of the NMEA sentence checksum checker.
// Instantiates nscc_parser and nscc_out_reg; depends on nscc_pkg.
//
//  channel | handshake                | payload             | dir
//  --------+--------------------------+---------------------+-----
//  in      | in_valid / in_stall      | in_data (in_beat_t) | in
//  out     | out_valid / out_stall    | out_data(out_beat_t)| out
//  cfg     | cfg_valid / cfg_ready    | cfg_data (policy)   | in
//
// One byte beat per cycle sustained unless a verdict waits on a stalled
// output. A taken beat is parsed from the input register; its verdict (last
// byte of a line that held a '$') enters the result register on advance.
// Reset clears the line state, the policy (strict) and both valid flags.
// A stalled output blocks only beats that would produce a verdict; other
// bytes keep flowing while a verdict waits.
module nmea_sentence_checksum_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  nscc_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output nscc_pkg::out_beat_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);
    import nscc_pkg::*;

    logic       in_valid_reg;
    in_beat_t   in_beat_reg;
    logic [1:0] policy_reg;
    logic       advance;
    logic       res_valid;
    out_beat_t  res;
    logic       out_free;
    logic       in_take;

    // Policy register: always ready; the user writes it only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_STRICT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    // Advance the held byte unless its verdict has nowhere to go.
    assign advance  = in_valid_reg && (!res_valid || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_beat_reg <= in_data;
        end
    end

    nscc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .beat      (in_beat_reg),
        .policy    (policy_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    nscc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .load_data (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> verif/tb.sv
// Self-checking testbench for nmea_sentence_checksum_checker.
// Drives byte beats and policy writes, predicts each verdict and checks it.
// Depends on nscc_pkg and the checker RTL in src.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nscc_pkg::*;

    // Pause after the last verdict before touching the policy or ending.
    // A line without '$' can still be in the pipe (input reg + parse stage).
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;

    // Line parser phases of the predictor.
    typedef enum logic [2:0] {
        SCAN_DOLLAR,
        IN_BODY,
        WANT_HI,
        WANT_LO,
        SUM_READY,
        NO_SUM
    } line_phase_t;

    // One queued byte beat; pinned beats carry a hand-written verdict.
    typedef struct {
        in_beat_t  beat;
        bit        pinned;
        out_beat_t want;
    } send_beat_t;

    typedef struct {
        logic [7:0] ch;
        bit         last;
        bit         pinned;
        verdict_t   v;
        logic [7:0] sum;
        logic [4:0] fields;
    } directed_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_data = POLICY_STRICT;

    // Predictor state: policy copy and the line being parsed.
    policy_t     checksum_mode = POLICY_STRICT;
    line_phase_t line_phase = SCAN_DOLLAR;
    logic [7:0]  body_xor = '0;
    int          hi_digit = 0;
    int          sent_sum = 0;
    logic [4:0]  body_commas = '0;

    send_beat_t line_beats_q[$];
    out_beat_t  verdicts_due_q[$];
    send_beat_t offered_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int fail_count = 0;
    int beats_queued = 0;
    int lines_queued = 0;
    int beats_accepted = 0;
    int verdicts_checked = 0;
    int input_stalls = 0;
    int verdict_seen[5] = '{default: 0};

    // Opening walk: extremes, each special case, one pinned verdict per line that holds a '$'.
    // Runs under the reset policy (strict).
    directed_row_t opening_rows[26] = '{
        // "$*00": empty body, sum 00 matches
        '{8'h24, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h2A, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h30, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h30, 1'b1, 1'b1, VERDICT_GOOD,     8'h00, 5'd0},
        // line without a dollar sign, byte extremes: no verdict
        '{8'h00, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'hFF, 1'b1, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        // "$,<LF>A": body cut by a control byte, trailing byte ignored
        '{8'h24, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h2C, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h0A, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h41, 1'b1, 1'b1, VERDICT_MISS_REJ, 8'h2C, 5'd1},
        // "$A*4": line ends after one digit
        '{8'h24, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h41, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h2A, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h34, 1'b1, 1'b1, VERDICT_BAD_REJ,  8'h41, 5'd0},
        // "$$*24Z": second dollar is a body byte, byte after digits ignored
        '{8'h24, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h24, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h2A, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h32, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h34, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h5A, 1'b1, 1'b1, VERDICT_GOOD,     8'h24, 5'd0},
        // "$<FF>*gg": digits that are not hex decode to a large value
        '{8'h24, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'hFF, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h2A, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h67, 1'b0, 1'b0, VERDICT_GOOD,     8'h00, 5'd0},
        '{8'h67, 1'b1, 1'b1, VERDICT_BAD_REJ,  8'hFF, 5'd0},
        // "$" alone: body ended by the line end
        '{8'h24, 1'b1, 1'b1, VERDICT_MISS_REJ, 8'h00, 5'd0}
    };

    nmea_sentence_checksum_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hex digit as the block reads it: above '9' minus 55, else minus 48.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c > CH_NINE)
            return int'(c) - int'(HEX_ALPHA_OFS);
        return int'(c) - int'(HEX_DIGIT_OFS);
    endfunction

    // Advance the line parser by one byte beat; on the last byte of a line
    // that held a '$', return 1 with the verdict beat the block must emit.
    function automatic bit nmea_advance(input in_beat_t beat, output out_beat_t verdict_beat);
        logic [7:0] c;
        verdict_t   bad_code;
        c = beat.line_byte;
        bad_code = (checksum_mode <= POLICY_BAD_ONLY) ? VERDICT_BAD_REJ : VERDICT_BAD_OK;
        verdict_beat = '0;
        case (line_phase)
            SCAN_DOLLAR:
            begin
                if (c == CH_DOLLAR)
                    line_phase = IN_BODY;
            end
            IN_BODY:
            begin
                if (c < CH_SPACE)
                    line_phase = NO_SUM;
                else if (c == CH_STAR)
                    line_phase = WANT_HI;
                else
                begin
                    body_xor ^= c;
                    if (c == CH_COMMA && body_commas < MAX_FIELDS)
                        body_commas++;
                end
            end
            WANT_HI:
            begin
                hi_digit = hex_nibble(c);
                line_phase = WANT_LO;
            end
            WANT_LO:
            begin
                sent_sum = hi_digit * 16 + hex_nibble(c);
                line_phase = SUM_READY;
            end
            default: ;
        endcase

        if (!beat.line_last || line_phase == SCAN_DOLLAR)
            return 1'b0;

        case (line_phase)
            IN_BODY, NO_SUM:
                verdict_beat.verdict = (checksum_mode == POLICY_STRICT) ?
                                       VERDICT_MISS_REJ : VERDICT_NOSUM_OK;
            SUM_READY:
                verdict_beat.verdict = (sent_sum == int'(body_xor)) ? VERDICT_GOOD : bad_code;
            default:
                verdict_beat.verdict = bad_code;
        endcase
        verdict_beat.computed_sum = body_xor;
        verdict_beat.field_count = body_commas;

        // Drop the line and go back to hunting for '$'.
        line_phase = SCAN_DOLLAR;
        body_xor = '0;
        hi_digit = 0;
        sent_sum = 0;
        body_commas = '0;
        return 1'b1;
    endfunction

    // Compare one received verdict beat with the oldest one due.
    task automatic check_verdict_beat(input out_beat_t got);
        out_beat_t want;
        if (got.verdict < 5)
            verdict_seen[got.verdict]++;
        if (verdicts_due_q.size() == 0)
        begin
            $error("verdict beat with none due: verdict %0d sum %02h fields %0d",
                   got.verdict, got.computed_sum, got.field_count);
            fail_count++;
            return;
        end
        want = verdicts_due_q.pop_front();
        verdicts_checked++;
        if (got.verdict !== want.verdict)
        begin
            $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
            fail_count++;
        end
        if (got.computed_sum !== want.computed_sum)
        begin
            $error("computed_sum: expected %02h, got %02h", want.computed_sum, got.computed_sum);
            fail_count++;
        end
        if (got.field_count !== want.field_count)
        begin
            $error("field_count: expected %0d, got %0d", want.field_count, got.field_count);
            fail_count++;
        end
    endtask

    // Sender: on an accepted beat, run the predictor; then offer the next
    // queued beat or idle. A stalled beat is held as it is.
    always @(posedge clk)
    begin
        out_beat_t predicted;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                input_stalls++;
            if (in_valid && !in_stall)
            begin
                beats_accepted++;
                if (nmea_advance(offered_item.beat, predicted) || offered_item.pinned)
                    verdicts_due_q.push_back(offered_item.pinned ? offered_item.want : predicted);
            end
            if (!in_valid || !in_stall)
            begin
                if (line_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_item = line_beats_q.pop_front();
                    in_valid <= 1'b1;
                    in_data <= offered_item.beat;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check accepted verdict beats, stall at random, and serve
    // long hold-off requests by counting cycles here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_verdict_beat(out_data);
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic logic [7:0] no_dollar_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        return (c == CH_DOLLAR) ? 8'h23 : c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 10) ? 8'(8'h30 + v) : 8'(8'h37 + v);
    endfunction

    // A checksum digit that is usually hex, sometimes lower case or any byte.
    function automatic logic [7:0] loose_digit();
        logic [7:0] c;
        if ($urandom_range(4) == 0)
            return 8'($urandom_range(255));
        c = hex_char(4'($urandom_range(15)));
        if (c > CH_NINE && $urandom_range(2) == 0)
            c |= 8'h20;
        return c;
    endfunction

    // Queue one random line. Most are well-formed sentences with random
    // content; the rest are cut short, lack the '$', or are pure noise.
    task automatic queue_sentence();
        logic [7:0] text[$];
        logic [7:0] c;
        logic [7:0] xsum;
        int roll;
        int body_len;
        int comma_pct;
        send_beat_t item;
        roll = $urandom_range(99);
        xsum = '0;
        if (roll >= 85)
        begin
            repeat ($urandom_range(1, 12))
                text.push_back((roll < 93) ? no_dollar_byte() : 8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 3))
                    text.push_back(no_dollar_byte());
            text.push_back(CH_DOLLAR);
            // Long comma-heavy bodies push the field count into saturation.
            if ($urandom_range(9) == 0)
            begin
                body_len = $urandom_range(20, 40);
                comma_pct = 60;
            end
            else
            begin
                body_len = $urandom_range(0, 12);
                comma_pct = 15;
            end
            repeat (body_len)
            begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if ($urandom_range(99) < comma_pct || c == CH_STAR)
                    c = CH_COMMA;
                xsum ^= c;
                text.push_back(c);
            end
            if (roll < 65)
            begin
                text.push_back(CH_STAR);
                if ($urandom_range(99) < 60)
                begin
                    text.push_back(hex_char(xsum[7:4]));
                    text.push_back(hex_char(xsum[3:0]));
                end
                else
                begin
                    repeat (2)
                        text.push_back(loose_digit());
                end
                case ($urandom_range(3))
                    2:
                    begin
                        text.push_back(8'h0D);
                        text.push_back(8'h0A);
                    end
                    3:
                    begin
                        repeat ($urandom_range(1, 3))
                            text.push_back(8'($urandom_range(255)));
                    end
                    default: ;
                endcase
            end
            else if (roll < 75)
            begin
                // Control byte ends the body, or the line simply ends.
                if ($urandom_range(2) != 0)
                begin
                    text.push_back(8'($urandom_range(0, 8'h1F)));
                    repeat ($urandom_range(0, 4))
                        text.push_back(8'($urandom_range(255)));
                end
            end
            else
            begin
                text.push_back(CH_STAR);
                if ($urandom_range(1) != 0)
                    text.push_back(loose_digit());
            end
        end
        foreach (text[i])
        begin
            item.beat.line_byte = text[i];
            item.beat.line_last = (i == text.size() - 1);
            item.pinned = 1'b0;
            item.want = '0;
            line_beats_q.push_back(item);
        end
        beats_queued += text.size();
        lines_queued++;
    endtask

    // Hold until every queued beat is accepted and every verdict has come
    // back, then let the pipe settle. Leftovers after the limit are failures.
    task automatic drain_lines();
        int n;
        while (beats_accepted < beats_queued)
            @(posedge clk);
        for (n = 0; n < DRAIN_LIMIT && verdicts_due_q.size() != 0; n++)
            @(posedge clk);
        if (verdicts_due_q.size() != 0)
        begin
            $error("%0d verdict beats never arrived", verdicts_due_q.size());
            fail_count += verdicts_due_q.size();
            verdicts_due_q.delete();
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write the policy register; only called with the checker idle.
    task automatic write_policy(input policy_t mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        checksum_mode = mode;
    endtask

    // One random phase: policy, idle mix, about n_beats beats of lines.
    // With squeeze set, the receiver holds off for a long stretch first.
    task automatic run_phase(input policy_t mode, input int send_pct, input int recv_pct,
                             input int n_beats, input bit squeeze);
        int target;
        write_policy(mode);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (squeeze)
            hold_requests++;
        target = beats_queued + n_beats;
        while (beats_queued < target)
            queue_sentence();
        drain_lines();
    endtask

    initial
    begin
        send_beat_t item;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Opening walk under the reset policy, sender and receiver idling.
        send_idle_pct = 33;
        recv_idle_pct = 45;
        foreach (opening_rows[i])
        begin
            item.beat.line_byte = opening_rows[i].ch;
            item.beat.line_last = opening_rows[i].last;
            item.pinned = opening_rows[i].pinned;
            item.want.verdict = opening_rows[i].v;
            item.want.computed_sum = opening_rows[i].sum;
            item.want.field_count = opening_rows[i].fields;
            line_beats_q.push_back(item);
            if (opening_rows[i].last)
                lines_queued++;
        end
        beats_queued += $size(opening_rows);
        drain_lines();

        // Random lines: swap the idle mix, then run flat out, visiting
        // every policy value including the unused code at the top.
        run_phase(POLICY_BAD_ONLY,   33, 45, 200, 1'b0);
        run_phase(POLICY_ACCEPT_ALL, 45, 33, 200, 1'b0);
        run_phase(POLICY_ACCEPT_ALT,  0,  0, 150, 1'b0);
        run_phase(POLICY_STRICT,      0,  0, 250, 1'b1);

        $display("covered %0d beats in %0d lines under all four policies, %0d verdicts checked",
                 beats_accepted, lines_queued, verdicts_checked);
        $display("verdicts good/nosum-ok/bad-ok/bad-rej/miss-rej %0d/%0d/%0d/%0d/%0d, %0d stalled",
                 verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
                 verdict_seen[4], input_stalls);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/nscc_pkg.sv
src/nscc_parser.sv
src/nscc_out_reg.sv
src/nmea_sentence_checksum_checker.sv
verif/tb.sv
